// File: rtl/afarm_pkg.sv
`default_nettype none

package afarm_pkg;

  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 112;
  localparam int unsigned DIV_STEPS  = 32;
  localparam int unsigned DIV_CNT_W  = 6;

  localparam logic [23:0] BYTES_MAX = 24'hFF_FFFF;

  localparam logic [1:0] KIND_ENQ   = 2'd0;
  localparam logic [1:0] KIND_DEQ   = 2'd1;
  localparam logic [1:0] KIND_LIMIT = 2'd2;
  localparam logic [1:0] KIND_SLOT  = 2'd3;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_KEEP   = 2'd1;
  localparam logic [1:0] ACT_REDUCE = 2'd2;
  localparam logic [1:0] ACT_ALIAS  = 2'd3;

  localparam logic [2:0] ST_ADMIT     = 3'd0;
  localparam logic [2:0] ST_LIM_DROP  = 3'd1;
  localparam logic [2:0] ST_CAP_DROP  = 3'd2;
  localparam logic [2:0] ST_DEQUEUED  = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;
  localparam logic [2:0] ST_RESIZED   = 3'd5;
  localparam logic [2:0] ST_SLOT_DONE = 3'd6;

  localparam logic [2:0] REG_START_LIMIT = 3'd0;
  localparam logic [2:0] REG_INT_CAP     = 3'd1;
  localparam logic [2:0] REG_LIMIT_CAP   = 3'd2;
  localparam logic [2:0] REG_METER_THR   = 3'd3;
  localparam logic [2:0] REG_TARGET_DLY  = 3'd4;

  localparam logic [7:0]  START_LIMIT_RST = 8'd50;
  localparam logic [7:0]  INT_CAP_RST     = 8'd50;
  localparam logic [7:0]  LIMIT_CAP_RST   = 8'd100;
  localparam logic [23:0] METER_THR_RST   = 24'd2000;
  localparam logic [31:0] TARGET_DLY_RST  = 32'd2000000;

  localparam logic signed [3:0] CONG_MAX = 4'sd5;
  localparam logic signed [3:0] CONG_MIN = -4'sd5;

  typedef struct packed {
    logic        wr_en;
    logic [2:0]  idx;
    logic [31:0] wdata;
  } cfg_bus_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic meter_acc;
    logic meter_close;
    logic take_sample;
    logic div_start;
    logic div_sample;
    logic delay_zero;
    logic delay_load;
    logic post;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       queue_nz;
    logic       meter_due;
    logic       span_nz;
    logic       rate_nz;
    logic       div_busy;
    logic       div_done;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/afarm_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. Quotients above 32 bits
// saturate; the divisor is never zero when started.
module afarm_div #(
  parameter int unsigned FRAC_BITS = 20
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [32+FRAC_BITS-1:0] dividend,
  input  wire logic [31:0]             divisor,
  output logic      [31:0]             quotient,
  output logic                         busy,
  output logic                         done
);

  logic [31:0] rem;
  logic [31:0] lo;
  logic [31:0] dsr;
  logic [afarm_pkg::DIV_CNT_W-1:0] cnt;

  logic [31:0] hi_ext;
  logic        ovf;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  always_comb begin
    hi_ext = 32'(dividend[32+FRAC_BITS-1:32]);
    ovf    = hi_ext >= divisor;
    trial  = {rem, lo[31]};
    diff   = trial - {1'b0, dsr};
    ge     = trial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= ovf ? '0 : afarm_pkg::DIV_CNT_W'(afarm_pkg::DIV_STEPS);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= hi_ext;
      dsr <= divisor;
      lo  <= ovf ? '1 : dividend[31:0];
    end else if (busy && cnt != '0) begin
      rem <= ge ? diff[31:0] : trial[31:0];
      lo  <= {lo[30:0], ge};
    end
  end

  assign quotient = lo;

endmodule

`default_nettype wire

// File: rtl/afarm_datapath.sv
`default_nettype none

module afarm_datapath #(
  parameter int unsigned RATE_FRAC_BITS = 20,
  parameter int unsigned COUNT_BITS     = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire afarm_pkg::cfg_bus_t               cfg,
  output logic [31:0]                            prdata,
  input  wire logic [1:0]                        in_kind,
  input  wire logic [afarm_pkg::IN_DATA_W-1:0]   in_data,
  input  wire afarm_pkg::cmd_t                   cmd,
  output afarm_pkg::dp_stat_t                    stat,
  output logic [2:0]                             out_kind,
  output logic [afarm_pkg::OUT_DATA_W-1:0]       out_data
);

  localparam int unsigned DIV_W     = 32 + RATE_FRAC_BITS;
  localparam int unsigned COUNT_MAX = (1 << COUNT_BITS) - 1;

  // configuration
  logic [7:0]  start_limit;
  logic [7:0]  internal_capacity;
  logic [7:0]  limit_cap;
  logic [23:0] meter_threshold;
  logic [31:0] target_delay;

  // queue and meter state
  logic [7:0]        packet_count;
  logic [23:0]       byte_count;
  logic [7:0]        limit_now;
  logic signed [3:0] congestion;
  logic              measuring;
  logic [31:0]       meter_start;
  logic [31:0]       meter_bytes;
  logic [31:0]       rate_estimate;
  logic [31:0]       previous_delay;
  logic [1:0]        last_action;

  // current transaction
  logic [1:0]  kind_q;
  logic [15:0] pkt_q;
  logic [31:0] now_q;
  logic [1:0]  act_q;
  logic [2:0]  status_q;
  logic [31:0] delay_q;

  logic [7:0]  cap_eff;
  logic [8:0]  cnt_inc;
  logic [24:0] byte_sum;
  logic        limit_drop;
  logic        cap_drop;
  logic [23:0] byte_sub;
  logic [1:0]  act_eff;
  logic [8:0]  limit_inc;
  logic [7:0]  limit_dec;
  logic [7:0]  limit_floor;
  logic [7:0]  limit_new;
  logic        meter_open;
  logic        meter_eff;
  logic [31:0] meter_base;
  logic [31:0] span;
  logic [32:0] rate_sum;
  logic        slot_clear;

  logic [DIV_W-1:0] div_dividend;
  logic [31:0]      div_divisor;
  logic [31:0]      div_q;
  logic             div_busy;
  logic             div_done;

  afarm_div #(
    .FRAC_BITS(RATE_FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .quotient(div_q),
    .busy    (div_busy),
    .done    (div_done)
  );

  always_comb begin
    cap_eff    = (32'(internal_capacity) > COUNT_MAX) ? 8'(COUNT_MAX) : internal_capacity;
    cnt_inc    = {1'b0, packet_count} + 9'd1;
    byte_sum   = {1'b0, byte_count} + 25'(pkt_q);
    limit_drop = cnt_inc > {1'b0, limit_now};
    cap_drop   = (cnt_inc > {1'b0, cap_eff}) || byte_sum[24];
    byte_sub   = (byte_count > 24'(pkt_q)) ? byte_count - 24'(pkt_q) : 24'd0;

    act_eff = (act_q == afarm_pkg::ACT_ALIAS) ? afarm_pkg::ACT_KEEP : act_q;
    limit_inc = {1'b0, limit_now} + 9'd1;
    limit_dec = (limit_now != 8'd0) ? limit_now - 8'd1 : 8'd0;
    if (limit_dec < packet_count) limit_floor = packet_count;
    else limit_floor = limit_dec;
    if (limit_floor == 8'd0) limit_floor = 8'd1;
    case (act_eff)
      afarm_pkg::ACT_ADD:    limit_new = (limit_inc <= {1'b0, limit_cap}) ? limit_inc[7:0]
                                                                           : limit_cap;
      afarm_pkg::ACT_REDUCE: limit_new = limit_floor;
      default:               limit_new = limit_now;
    endcase

    meter_open = (byte_count >= meter_threshold) && !measuring;
    meter_eff  = measuring || meter_open;
    meter_base = meter_open ? 32'd0 : meter_bytes;
    span       = now_q - meter_start;
    rate_sum   = {1'b0, rate_estimate} + {1'b0, div_q};

    slot_clear = ({delay_q, 1'b0} < {1'b0, target_delay}) &&
                 ({previous_delay, 1'b0} < {1'b0, target_delay}) &&
                 (last_action == afarm_pkg::ACT_KEEP) && (rate_estimate != 32'd0);

    if (cmd.div_sample) begin
      div_dividend = {meter_bytes, {RATE_FRAC_BITS{1'b0}}};
      div_divisor  = span;
    end else begin
      div_dividend = {8'd0, byte_count, {RATE_FRAC_BITS{1'b0}}};
      div_divisor  = rate_estimate;
    end
  end

  always_comb begin
    stat.kind      = kind_q;
    stat.queue_nz  = packet_count != 8'd0;
    stat.meter_due = measuring && (meter_bytes >= 32'(meter_threshold));
    stat.span_nz   = span != 32'd0;
    stat.rate_nz   = rate_estimate != 32'd0;
    stat.div_busy  = div_busy;
    stat.div_done  = div_done;
  end

  always_comb begin
    case (cfg.idx)
      afarm_pkg::REG_START_LIMIT: prdata = 32'(start_limit);
      afarm_pkg::REG_INT_CAP:     prdata = 32'(internal_capacity);
      afarm_pkg::REG_LIMIT_CAP:   prdata = 32'(limit_cap);
      afarm_pkg::REG_METER_THR:   prdata = 32'(meter_threshold);
      afarm_pkg::REG_TARGET_DLY:  prdata = target_delay;
      default:                    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_limit       <= afarm_pkg::START_LIMIT_RST;
      internal_capacity <= afarm_pkg::INT_CAP_RST;
      limit_cap         <= afarm_pkg::LIMIT_CAP_RST;
      meter_threshold   <= afarm_pkg::METER_THR_RST;
      target_delay      <= afarm_pkg::TARGET_DLY_RST;
      packet_count      <= 8'd0;
      byte_count        <= 24'd0;
      limit_now         <= afarm_pkg::START_LIMIT_RST;
      congestion        <= 4'sd0;
      measuring         <= 1'b0;
      meter_start       <= 32'd0;
      meter_bytes       <= 32'd0;
      rate_estimate     <= 32'd0;
      previous_delay    <= 32'd0;
      last_action       <= afarm_pkg::ACT_KEEP;
    end else begin
      if (cfg.wr_en) begin
        case (cfg.idx)
          afarm_pkg::REG_START_LIMIT: begin
            start_limit <= cfg.wdata[7:0];
            limit_now   <= cfg.wdata[7:0];
          end
          afarm_pkg::REG_INT_CAP:    internal_capacity <= cfg.wdata[7:0];
          afarm_pkg::REG_LIMIT_CAP:  limit_cap         <= cfg.wdata[7:0];
          afarm_pkg::REG_METER_THR:  meter_threshold   <= cfg.wdata[23:0];
          afarm_pkg::REG_TARGET_DLY: target_delay      <= cfg.wdata;
          default: ;
        endcase
      end

      if (cmd.exec) begin
        case (kind_q)
          afarm_pkg::KIND_ENQ: begin
            if (!limit_drop) begin
              if (cap_drop) begin
                if (congestion > afarm_pkg::CONG_MIN) congestion <= congestion - 4'sd1;
              end else begin
                packet_count <= cnt_inc[7:0];
                byte_count   <= byte_sum[23:0];
                if (congestion < afarm_pkg::CONG_MAX) congestion <= congestion + 4'sd1;
              end
            end
          end
          afarm_pkg::KIND_DEQ: begin
            if (packet_count != 8'd0) begin
              packet_count <= packet_count - 8'd1;
              byte_count   <= byte_sub;
            end
          end
          afarm_pkg::KIND_LIMIT: begin
            limit_now   <= limit_new;
            last_action <= act_eff;
          end
          default: ;
        endcase
      end

      if (cmd.meter_acc && meter_eff) begin
        measuring   <= 1'b1;
        meter_bytes <= meter_base + 32'(pkt_q);
        if (meter_open) meter_start <= now_q;
      end

      if (cmd.meter_close) begin
        if (cmd.take_sample) begin
          rate_estimate <= (rate_estimate == 32'd0) ? div_q : rate_sum[32:1];
        end
        meter_bytes <= 32'd0;
        if (byte_count > meter_threshold) begin
          meter_start <= now_q;
          measuring   <= 1'b1;
        end else begin
          measuring <= 1'b0;
        end
      end

      if (cmd.post) begin
        case (kind_q)
          afarm_pkg::KIND_LIMIT: previous_delay <= delay_q;
          afarm_pkg::KIND_SLOT: begin
            if (slot_clear) begin
              rate_estimate <= 32'd0;
              meter_bytes   <= 32'd0;
            end
            last_action <= afarm_pkg::ACT_KEEP;
          end
          default: ;
        endcase
      end
    end
  end

  // transaction fields, status and result payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_q <= in_kind;
      pkt_q  <= in_data[15:0];
      now_q  <= in_data[47:16];
      act_q  <= in_data[49:48];
    end
    if (cmd.exec) begin
      case (kind_q)
        afarm_pkg::KIND_ENQ: begin
          if (limit_drop)    status_q <= afarm_pkg::ST_LIM_DROP;
          else if (cap_drop) status_q <= afarm_pkg::ST_CAP_DROP;
          else               status_q <= afarm_pkg::ST_ADMIT;
        end
        afarm_pkg::KIND_DEQ:
          status_q <= (packet_count != 8'd0) ? afarm_pkg::ST_DEQUEUED : afarm_pkg::ST_EMPTY;
        afarm_pkg::KIND_LIMIT: status_q <= afarm_pkg::ST_RESIZED;
        default:               status_q <= afarm_pkg::ST_SLOT_DONE;
      endcase
    end
    if (cmd.delay_zero) delay_q <= 32'd0;
    else if (cmd.delay_load) delay_q <= div_q;
    else if (cmd.post && kind_q == afarm_pkg::KIND_SLOT && slot_clear) delay_q <= 32'd0;
    if (cmd.emit) begin
      out_kind <= status_q;
      out_data <= {4'd0, delay_q, rate_estimate, congestion, limit_now, byte_count,
                   packet_count};
    end
  end

endmodule

`default_nettype wire

// File: rtl/afarm_ctrl.sv
`default_nettype none

module afarm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  input  wire afarm_pkg::dp_stat_t stat,
  output afarm_pkg::cmd_t          cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EXEC   = 4'd1;
  localparam logic [3:0] S_MACC   = 4'd2;
  localparam logic [3:0] S_MCHK   = 4'd3;
  localparam logic [3:0] S_SDIV   = 4'd4;
  localparam logic [3:0] S_DSTART = 4'd5;
  localparam logic [3:0] S_DDIV   = 4'd6;
  localparam logic [3:0] S_POST   = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_valid;
  logic       out_free;

  assign s_tready = (state == S_IDLE) && !rst;
  assign m_tvalid = out_valid;
  assign out_free = !out_valid || m_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.kind == afarm_pkg::KIND_DEQ && stat.queue_nz) state_next = S_MACC;
        else state_next = S_DSTART;
      end
      S_MACC: begin
        cmd.meter_acc = 1'b1;
        state_next    = S_MCHK;
      end
      S_MCHK: begin
        if (stat.meter_due && stat.span_nz) begin
          cmd.div_start  = 1'b1;
          cmd.div_sample = 1'b1;
          state_next     = S_SDIV;
        end else if (stat.meter_due) begin
          cmd.meter_close = 1'b1;
          state_next      = S_DSTART;
        end else begin
          state_next = S_DSTART;
        end
      end
      S_SDIV: begin
        cmd.div_sample = 1'b1;
        if (stat.div_done) begin
          cmd.meter_close = 1'b1;
          cmd.take_sample = 1'b1;
          state_next      = S_DSTART;
        end
      end
      S_DSTART: begin
        if (stat.rate_nz) begin
          cmd.div_start = 1'b1;
          state_next    = S_DDIV;
        end else begin
          cmd.delay_zero = 1'b1;
          state_next     = S_POST;
        end
      end
      S_DDIV: begin
        if (stat.div_done) begin
          cmd.delay_load = 1'b1;
          state_next     = S_POST;
        end
      end
      S_POST: begin
        cmd.post   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/adaptive_fifo_admission_rate_meter_core.sv
// An input transaction passes through execute, a meter update (dequeues from a
// nonempty queue only), a rate-sample division when that dequeue closes a measurement
// over a nonzero span, the delay division while the rate is nonzero, post and emit; a
// saturating division finishes sooner. One item is in work at a time; the next is taken
// in the cycle after the result is registered; the shared 32-step divider paces items.
// Reset (rst, synchronous, active high) loads register defaults, empties the queue
// counters and clears the meter; the block is ready in the first cycle after reset.
`default_nettype none

module adaptive_fifo_admission_rate_meter_core #(
  parameter int unsigned RATE_FRAC_BITS = 20,
  parameter int unsigned COUNT_BITS     = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // pkt_bytes[15:0], now_us[47:16], action[49:48], zero pad
  input  wire logic [55:0]  s_tdata,
  // kind[1:0]
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // queued_packets[7:0], queued_bytes[31:8], buffer_limit[39:32],
  // congestion_score[43:40], departure_rate[75:44], delay_estimate[107:76], zero pad
  output logic [111:0]      m_tdata,
  // status[2:0]
  output logic [2:0]        m_tuser,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  afarm_pkg::cfg_bus_t cfg;
  afarm_pkg::cmd_t     cmd;
  afarm_pkg::dp_stat_t stat;

  assign pready    = 1'b1;
  assign cfg.wr_en = psel && penable && pwrite && pready;
  assign cfg.idx   = paddr[4:2];
  assign cfg.wdata = pwdata;

  afarm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  afarm_datapath #(
    .RATE_FRAC_BITS(RATE_FRAC_BITS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .prdata  (prdata),
    .in_kind (s_tuser),
    .in_data (s_tdata),
    .cmd     (cmd),
    .stat    (stat),
    .out_kind(m_tuser),
    .out_data(m_tdata)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second transaction taken while one is in work");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider restarted while busy");

  a_score_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[43:40]) >= afarm_pkg::CONG_MIN &&
                  $signed(m_tdata[43:40]) <= afarm_pkg::CONG_MAX))
    else $error("congestion score out of range");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser <= afarm_pkg::ST_SLOT_DONE))
    else $error("undefined status code on result");

endmodule

`default_nettype wire

// File: dv/adaptive_fifo_admission_rate_meter_core_test.sv
`default_nettype none

module adaptive_fifo_admission_rate_meter_core_test;

  localparam int unsigned FRAC = 20;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] pkt;
    logic [31:0] now;
    logic [1:0]  act;
  } queue_op_t;

  typedef struct {
    logic [2:0]  status;
    logic [7:0]  pkts;
    logic [23:0] bytes;
    logic [7:0]  limit;
    logic [3:0]  score;
    logic [31:0] rate;
    logic [31:0] delay;
  } queue_report_t;

  typedef enum { MIX_NORMAL, MIX_CEILING } mix_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic [55:0]  s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tready = 1'b0;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  wire          s_tready;
  wire          m_tvalid;
  wire [111:0]  m_tdata;
  wire [2:0]    m_tuser;
  wire [31:0]   prdata;
  wire          pready;

  adaptive_fifo_admission_rate_meter_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // shadow of the block's registers and queue state
  int unsigned cfg_start, cfg_int_cap, cfg_limit_cap, cfg_meter_thr, cfg_target;
  int unsigned held_pkts, held_bytes, cur_limit;
  int unsigned meter_t0, meter_acc, rate_est, prev_delay;
  int          score;
  bit          meter_open;
  logic [1:0]  last_act;

  queue_report_t reports_due[$];
  int unsigned   clock_us = 0;
  int unsigned   burst_left = 0;
  bit            filling = 1'b0;
  int            errors = 0;
  logic [7:0]    sink_phase = '0;
  logic [1:0]    sink_mode = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic load_reset_state();
    cfg_start     = afarm_pkg::START_LIMIT_RST;
    cfg_int_cap   = afarm_pkg::INT_CAP_RST;
    cfg_limit_cap = afarm_pkg::LIMIT_CAP_RST;
    cfg_meter_thr = afarm_pkg::METER_THR_RST;
    cfg_target    = afarm_pkg::TARGET_DLY_RST;
    held_pkts     = 0;
    held_bytes    = 0;
    cur_limit     = cfg_start;
    score         = 0;
    meter_open    = 1'b0;
    meter_t0      = 0;
    meter_acc     = 0;
    rate_est      = 0;
    prev_delay    = 0;
    last_act      = afarm_pkg::ACT_KEEP;
  endtask

  function automatic int unsigned delay_us();
    longint unsigned q;
    if (rate_est == 0) return 0;
    q = held_bytes;
    q = (q << FRAC) / rate_est;
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(q);
  endfunction

  function automatic void update_rate_meter(input int unsigned pkt, input int unsigned now);
    int unsigned     span;
    longint unsigned smp;
    if (held_bytes >= cfg_meter_thr && !meter_open) begin
      meter_t0   = now;
      meter_acc  = 0;
      meter_open = 1'b1;
    end
    if (meter_open) begin
      meter_acc += pkt;
      if (meter_acc >= cfg_meter_thr) begin
        span = now - meter_t0;
        if (span != 0) begin
          smp = meter_acc;
          smp = (smp << FRAC) / span;
          if (smp > 64'hFFFF_FFFF) smp = 64'hFFFF_FFFF;
          if (rate_est == 0) rate_est = 32'(smp);
          else rate_est = 32'((rate_est + smp) >> 1);
        end
        meter_acc  = 0;
        meter_open = (held_bytes > cfg_meter_thr);
        if (meter_open) meter_t0 = now;
      end
    end
  endfunction

  function automatic queue_report_t process_queue_op(input queue_op_t op);
    queue_report_t   r;
    logic [1:0]      act;
    int unsigned     nl;
    longint unsigned d;
    longint unsigned p;
    r.status = afarm_pkg::ST_ADMIT;
    case (op.kind)
      afarm_pkg::KIND_ENQ: begin
        if (held_pkts + 1 > cur_limit) begin
          r.status = afarm_pkg::ST_LIM_DROP;
        end else if (held_pkts + 1 > cfg_int_cap ||
                     held_bytes + op.pkt > afarm_pkg::BYTES_MAX) begin
          r.status = afarm_pkg::ST_CAP_DROP;
          if (score > afarm_pkg::CONG_MIN) score--;
        end else begin
          held_pkts++;
          held_bytes += op.pkt;
          if (score < afarm_pkg::CONG_MAX) score++;
        end
      end
      afarm_pkg::KIND_DEQ: begin
        if (held_pkts == 0) begin
          r.status = afarm_pkg::ST_EMPTY;
        end else begin
          r.status = afarm_pkg::ST_DEQUEUED;
          held_pkts--;
          held_bytes = (held_bytes > op.pkt) ? held_bytes - op.pkt : 0;
          update_rate_meter(op.pkt, op.now);
        end
      end
      afarm_pkg::KIND_LIMIT: begin
        r.status = afarm_pkg::ST_RESIZED;
        act = (op.act == afarm_pkg::ACT_ALIAS) ? afarm_pkg::ACT_KEEP : op.act;
        nl = cur_limit;
        if (act == afarm_pkg::ACT_ADD) begin
          nl = (cur_limit + 1 <= cfg_limit_cap) ? cur_limit + 1 : cfg_limit_cap;
        end else if (act == afarm_pkg::ACT_REDUCE) begin
          nl = (cur_limit > 0) ? cur_limit - 1 : 0;
          if (nl < held_pkts) nl = held_pkts;
          if (nl < 1) nl = 1;
        end
        cur_limit  = nl & 32'hFF;
        last_act   = act;
        prev_delay = delay_us();
      end
      default: begin
        r.status = afarm_pkg::ST_SLOT_DONE;
        d = delay_us();
        p = prev_delay;
        // rate is forgotten only after a calm slot with the limit left alone
        if (2 * d < cfg_target && 2 * p < cfg_target && last_act == afarm_pkg::ACT_KEEP &&
            rate_est != 0) begin
          rate_est  = 0;
          meter_acc = 0;
        end
        last_act = afarm_pkg::ACT_KEEP;
      end
    endcase
    r.pkts  = 8'(held_pkts);
    r.bytes = 24'(held_bytes);
    r.limit = 8'(cur_limit);
    r.score = 4'(score);
    r.rate  = rate_est;
    r.delay = delay_us();
    return r;
  endfunction

  function automatic queue_op_t op_of(input logic [1:0] k, input logic [15:0] p,
                                      input logic [31:0] t, input logic [1:0] a);
    queue_op_t op;
    op.kind = k;
    op.pkt  = p;
    op.now  = t;
    op.act  = a;
    return op;
  endfunction

  function automatic queue_op_t draw_op(input mix_t mix);
    queue_op_t   op;
    int unsigned roll;
    int unsigned p_enq, p_deq, p_lim;
    roll = $urandom_range(0, 99);
    if (mix == MIX_CEILING) begin
      p_enq = 75; p_deq = 20; p_lim = 3;
    end else if (filling) begin
      p_enq = 55; p_deq = 27; p_lim = 10;
    end else begin
      p_enq = 27; p_deq = 55; p_lim = 10;
    end
    if (roll < p_enq) op.kind = afarm_pkg::KIND_ENQ;
    else if (roll < p_enq + p_deq) op.kind = afarm_pkg::KIND_DEQ;
    else if (roll < p_enq + p_deq + p_lim) op.kind = afarm_pkg::KIND_LIMIT;
    else op.kind = afarm_pkg::KIND_SLOT;
    op.act = 2'($urandom_range(0, 3));
    if (mix == MIX_CEILING) begin
      // big arrivals, tiny departures: byte count climbs towards 24 bits
      if (op.kind == afarm_pkg::KIND_ENQ) op.pkt = 16'($urandom_range(60000, 65535));
      else op.pkt = 16'($urandom_range(0, 200));
      if (op.kind == afarm_pkg::KIND_LIMIT && $urandom_range(0, 3) != 0)
        op.act = afarm_pkg::ACT_ADD;
    end else begin
      case ($urandom_range(0, 9))
        0:       op.pkt = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        1, 2, 3: op.pkt = 16'($urandom);
        default: op.pkt = 16'($urandom_range(40, 1500));
      endcase
    end
    if ($urandom_range(0, 49) == 0) clock_us = $urandom;
    else clock_us += $urandom_range(0, 2500);
    op.now = clock_us;
    return op;
  endfunction

  task automatic send_op(input queue_op_t op);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, op.act, op.now, op.pkt};
    s_tuser  <= op.kind;
    do @(posedge clk); while (!s_tready);
    reports_due.insert(reports_due.size(), process_queue_op(op));
  endtask

  task automatic wait_all_reported();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // read back straight after
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== val) flag_mismatch("register readback", prdata, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      afarm_pkg::REG_START_LIMIT: begin
        cfg_start = val[7:0];
        cur_limit = val[7:0];
      end
      afarm_pkg::REG_INT_CAP:    cfg_int_cap   = val[7:0];
      afarm_pkg::REG_LIMIT_CAP:  cfg_limit_cap = val[7:0];
      afarm_pkg::REG_METER_THR:  cfg_meter_thr = val[23:0];
      afarm_pkg::REG_TARGET_DLY: cfg_target    = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [7:0] start, input logic [7:0] cap,
                           input logic [7:0] lcap, input logic [23:0] thr,
                           input logic [31:0] target);
    wait_all_reported();
    repeat (8) @(posedge clk);
    write_reg(afarm_pkg::REG_START_LIMIT, {24'd0, start});
    write_reg(afarm_pkg::REG_INT_CAP, {24'd0, cap});
    write_reg(afarm_pkg::REG_LIMIT_CAP, {24'd0, lcap});
    write_reg(afarm_pkg::REG_METER_THR, {8'd0, thr});
    write_reg(afarm_pkg::REG_TARGET_DLY, target);
  endtask

  task automatic run_traffic(input int n, input mix_t mix);
    int gap;
    int fill_left;
    fill_left = 0;
    for (int i = 0; i < n; i++) begin
      if (fill_left == 0) begin
        filling   = ~filling;
        fill_left = $urandom_range(20, 60);
      end
      fill_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          @(negedge clk);
          s_tvalid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
      burst_left--;
      if ($urandom_range(0, 199) == 0) wait_all_reported();
      send_op(draw_op(mix));
    end
    wait_all_reported();
  endtask

  task automatic test_directed();
    configure(8'd4, 8'd3, afarm_pkg::LIMIT_CAP_RST, 24'd1000, afarm_pkg::TARGET_DLY_RST);
    // nothing to take
    send_op(op_of(afarm_pkg::KIND_DEQ, 16'd100, 32'd0, afarm_pkg::ACT_KEEP));
    send_op(op_of(afarm_pkg::KIND_SLOT, 16'd0, 32'd0, afarm_pkg::ACT_ADD));
    send_op(op_of(afarm_pkg::KIND_LIMIT, 16'd0, 32'd0, afarm_pkg::ACT_KEEP));
    send_op(op_of(afarm_pkg::KIND_LIMIT, 16'd0, 32'd0, afarm_pkg::ACT_ALIAS));
    send_op(op_of(afarm_pkg::KIND_ENQ, 16'h0000, 32'd10, afarm_pkg::ACT_ADD));
    send_op(op_of(afarm_pkg::KIND_ENQ, 16'hFFFF, 32'd20, afarm_pkg::ACT_REDUCE));
    send_op(op_of(afarm_pkg::KIND_ENQ, 16'd2000, 32'd30, afarm_pkg::ACT_ALIAS));
    // capacity full
    send_op(op_of(afarm_pkg::KIND_ENQ, 16'd500, 32'd40, afarm_pkg::ACT_KEEP));
    // held by occupancy
    send_op(op_of(afarm_pkg::KIND_LIMIT, 16'd0, 32'd50, afarm_pkg::ACT_REDUCE));
    // over the limit
    send_op(op_of(afarm_pkg::KIND_ENQ, 16'd1, 32'd60, afarm_pkg::ACT_KEEP));
    send_op(op_of(afarm_pkg::KIND_LIMIT, 16'd0, 32'd70, afarm_pkg::ACT_ADD));
    // opens, zero span
    send_op(op_of(afarm_pkg::KIND_DEQ, 16'd1500, 32'd100, afarm_pkg::ACT_KEEP));
    // first sample
    send_op(op_of(afarm_pkg::KIND_DEQ, 16'd1200, 32'd300, afarm_pkg::ACT_KEEP));
    // bytes floor at 0
    send_op(op_of(afarm_pkg::KIND_DEQ, 16'hFFFF, 32'hFFFF_FFFF, afarm_pkg::ACT_ALIAS));
    send_op(op_of(afarm_pkg::KIND_DEQ, 16'd10, 32'd400, afarm_pkg::ACT_KEEP));
    send_op(op_of(afarm_pkg::KIND_LIMIT, 16'd0, 32'd500, afarm_pkg::ACT_REDUCE));
    // reduce blocks clear
    send_op(op_of(afarm_pkg::KIND_SLOT, 16'd0, 32'd600, afarm_pkg::ACT_KEEP));
    send_op(op_of(afarm_pkg::KIND_LIMIT, 16'd0, 32'd700, afarm_pkg::ACT_KEEP));
    // calm slot, rate cleared
    send_op(op_of(afarm_pkg::KIND_SLOT, 16'd0, 32'd0, afarm_pkg::ACT_KEEP));
    send_op(op_of(afarm_pkg::KIND_ENQ, 16'hFFFF, 32'd0, afarm_pkg::ACT_ALIAS));
    wait_all_reported();
  endtask

  task automatic test_default_traffic();
    configure(afarm_pkg::START_LIMIT_RST, afarm_pkg::INT_CAP_RST, afarm_pkg::LIMIT_CAP_RST,
              afarm_pkg::METER_THR_RST, afarm_pkg::TARGET_DLY_RST);
    run_traffic(250, MIX_NORMAL);
  endtask

  task automatic test_low_extremes();
    configure(8'd1, 8'd1, 8'd1, 24'd0, 32'd0);
    run_traffic(150, MIX_NORMAL);
  endtask

  task automatic test_high_extremes();
    configure(8'd255, 8'd255, 8'd255, 24'hFF_FFFF, 32'hFFFF_FFFF);
    run_traffic(250, MIX_NORMAL);
  endtask

  task automatic test_random_settings();
    logic [23:0] thr;
    logic [31:0] target;
    repeat (3) begin
      thr    = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 8000));
      target = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 5_000_000);
      configure(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                8'($urandom_range(1, 255)), thr, target);
      run_traffic(150, MIX_NORMAL);
    end
  endtask

  task automatic test_byte_ceiling();
    configure(8'd255, 8'd255, 8'd255, afarm_pkg::METER_THR_RST, afarm_pkg::TARGET_DLY_RST);
    run_traffic(400, MIX_CEILING);
  endtask

  // receiver back-pressure, mode picked afresh each time the phase counter wraps
  always @(negedge clk) begin
    sink_phase <= sink_phase + 8'd1;
    if (sink_phase == 8'd0) sink_mode <= 2'($urandom_range(0, 3));
    case (sink_mode)
      2'd0:    m_tready <= 1'b1;
      2'd1:    m_tready <= ($urandom_range(0, 1) != 0);
      2'd2:    m_tready <= (sink_phase % 6 == 0);
      default: m_tready <= ($urandom_range(0, 4) != 0);
    endcase
  end

  always @(posedge clk) begin : result_check
    queue_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (reports_due.size() == 0) begin
        flag_mismatch("transaction with nothing due", {29'd0, m_tuser}, 32'd0);
      end else begin
        want = reports_due.pop_front();
        if (m_tuser !== want.status)
          flag_mismatch("status", {29'd0, m_tuser}, {29'd0, want.status});
        if (m_tdata[7:0] !== want.pkts)
          flag_mismatch("queued_packets", {24'd0, m_tdata[7:0]}, {24'd0, want.pkts});
        if (m_tdata[31:8] !== want.bytes)
          flag_mismatch("queued_bytes", {8'd0, m_tdata[31:8]}, {8'd0, want.bytes});
        if (m_tdata[39:32] !== want.limit)
          flag_mismatch("buffer_limit", {24'd0, m_tdata[39:32]}, {24'd0, want.limit});
        if (m_tdata[43:40] !== want.score)
          flag_mismatch("congestion_score", {28'd0, m_tdata[43:40]}, {28'd0, want.score});
        if (m_tdata[75:44] !== want.rate)
          flag_mismatch("departure_rate", m_tdata[75:44], want.rate);
        if (m_tdata[107:76] !== want.delay)
          flag_mismatch("delay_estimate", m_tdata[107:76], want.delay);
      end
    end
  end

  initial begin
    load_reset_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_default_traffic();
    test_low_extremes();
    test_high_extremes();
    test_random_settings();
    test_byte_ceiling();
    wait_all_reported();
    repeat (100) @(posedge clk);
    if (errors == 0 && reports_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/afarm_pkg.sv
rtl/afarm_div.sv
rtl/afarm_datapath.sv
rtl/afarm_ctrl.sv
rtl/adaptive_fifo_admission_rate_meter_core.sv
dv/adaptive_fifo_admission_rate_meter_core_test.sv
